### hw/rtl/base64_strict_decoder_macros.svh
// Assertion macros for the strict base64 decoder.
// Used by the top level only; needs no package.
`ifndef BASE64_STRICT_DECODER_MACROS_SVH
`define BASE64_STRICT_DECODER_MACROS_SVH

// cond must never hold outside reset
`define B64SD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("b64sd: forbidden condition seen");

// a implies b in the same cycle
`define B64SD_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("b64sd: implication failed");

// a implies b in the next cycle
`define B64SD_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("b64sd: next-cycle implication failed");

`endif

### hw/rtl/b64sd_pkg.sv
// Shared types, codes and character tables of the strict base64 decoder.
// No dependencies; imported by every module of the block.
package b64sd_pkg;

	typedef enum logic [2:0] {
		CLS_BLANK,
		CLS_LETTER,
		CLS_PAD,
		CLS_BAD,
		CLS_END
	} char_class_t;

	typedef enum logic [1:0] {
		PAD_DATA,
		PAD_WANT_SECOND,
		PAD_DONE
	} pad_mode_t;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_BADCHAR    = 3'd1;
	localparam status_t ST_OVERFLOW   = 3'd2;
	localparam status_t ST_BADPAD     = 3'd3;
	localparam status_t ST_LEFTOVER   = 3'd4;
	localparam status_t ST_INCOMPLETE = 3'd5;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [7:0] CH_PAD   = 8'h3d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		char_class_t cls;
		logic [5:0]  val;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c >= 8'd9 && c <= 8'd13) || c == CH_SPACE;
	endfunction

	// bit 6 set: not a base64 letter
	function automatic logic [6:0] letter_value(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			t = c - 8'h41;
			return {1'b0, t[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			t = c - 8'h47;
			return {1'b0, t[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c + 8'h04;
			return {1'b0, t[5:0]};
		end else if (c == CH_PLUS) begin
			return 7'd62;
		end else if (c == CH_SLASH) begin
			return 7'd63;
		end
		return 7'd64;
	endfunction

endpackage

### hw/rtl/b64sd_front.sv
// Front end: accepts characters and classifies them for the item queue.
// Depends on b64sd_pkg. Whitespace is consumed here and never queued.
module b64sd_front import b64sd_pkg::*; (
	input  logic      [7:0] char_code,
	input  logic            end_of_text,
	input  logic            in_valid,
	output logic            in_stall,
	input  q_status_t       q_stat,
	output logic            push,
	output q_entry_t        push_entry
);

	logic [6:0] lv;

	assign lv       = letter_value(char_code);
	assign in_stall = q_stat.full;

	always_comb begin
		push_entry.val = lv[5:0];
		if (end_of_text) begin
			push_entry.cls = CLS_END;
		end else if (is_blank(char_code)) begin
			push_entry.cls = CLS_BLANK;
		end else if (char_code == CH_PAD) begin
			push_entry.cls = CLS_PAD;
		end else if (!lv[6]) begin
			push_entry.cls = CLS_LETTER;
		end else begin
			push_entry.cls = CLS_BAD;
		end
	end

	assign push = in_valid && !in_stall && push_entry.cls != CLS_BLANK;

endmodule

### hw/rtl/b64sd_queue.sv
// Short item queue between the front end and the decode back end.
// Depends on b64sd_pkg for the entry type and depth.
module b64sd_queue import b64sd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_entry,
	input  logic      pop,
	output q_entry_t  pop_entry,
	output q_status_t q_stat
);

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign pop_entry    = mem_q[rd_ptr_q];
	assign q_stat.full  = cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign q_stat.empty = cnt_q == '0;

endmodule

### hw/rtl/b64sd_back.sv
// Back end: decode state, padding rules, capacity check and output register.
// Depends on b64sd_pkg; takes classified items from b64sd_queue.
module b64sd_back import b64sd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic     [15:0] cfg_wr_data,
	input  q_status_t       q_stat,
	input  q_entry_t        pop_entry,
	output logic            pop,
	input  logic            out_stall,
	output logic            out_valid,
	output logic            item_kind,
	output logic      [7:0] data_byte,
	output status_t         status_code,
	output logic     [15:0] byte_count,
	output logic            last_item
);

	localparam int NEED_W = COUNT_WIDTH + 17;
	localparam int EXT_W  = COUNT_WIDTH + 16;

	logic [1:0]             phase_q, phase_d;
	logic [5:0]             partial_q, partial_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	pad_mode_t              pad_q, pad_d;
	status_t                err_q, err_d;
	logic [15:0]            capacity_q;

	logic [NEED_W-1:0] need;
	logic [EXT_W-1:0]  cnt_ext;
	logic              ovf;
	status_t           end_st;

	logic        res_valid;
	logic        res_kind;
	logic [7:0]  res_byte;
	status_t     res_status;
	logic [15:0] res_count;

	logic out_valid_q;

	assign pop = !q_stat.empty && (!out_valid_q || !out_stall);

	assign need = NEED_W'(count_q) + NEED_W'(phase_q == 2'd1 || phase_q == 2'd2);
	assign ovf  = need >= NEED_W'(capacity_q) || (phase_q != 2'd0 && count_q == '1);
	assign cnt_ext = EXT_W'(count_q);

	always_comb begin
		end_st = err_q;
		if (err_q == ST_OK) begin
			if (pad_q == PAD_WANT_SECOND) begin
				end_st = ST_BADPAD;
			end else if (pad_q == PAD_DONE) begin
				end_st = (partial_q != 6'd0) ? ST_LEFTOVER : ST_OK;
			end else if (phase_q != 2'd0) begin
				end_st = ST_INCOMPLETE;
			end
		end
	end

	always_comb begin
		phase_d    = phase_q;
		partial_d  = partial_q;
		count_d    = count_q;
		pad_d      = pad_q;
		err_d      = err_q;
		res_valid  = 1'b0;
		res_kind   = KIND_DATA;
		res_byte   = 8'd0;
		res_status = ST_OK;
		res_count  = 16'd0;
		if (pop) begin
			if (pop_entry.cls == CLS_END) begin
				res_valid  = 1'b1;
				res_kind   = KIND_STATUS;
				res_status = end_st;
				res_count  = (end_st == ST_OK) ? cnt_ext[15:0] : 16'd0;
				phase_d    = 2'd0;
				partial_d  = 6'd0;
				count_d    = '0;
				pad_d      = PAD_DATA;
				err_d      = ST_OK;
			end else if (err_q != ST_OK) begin
				// dropped until the end item
			end else if (pad_q == PAD_WANT_SECOND) begin
				if (pop_entry.cls == CLS_PAD) begin
					pad_d = PAD_DONE;
				end else begin
					err_d = ST_BADPAD;
				end
			end else if (pad_q != PAD_DATA) begin
				err_d = ST_BADPAD;
			end else begin
				unique case (pop_entry.cls)
					CLS_PAD: begin
						if (phase_q == 2'd2) begin
							pad_d = PAD_WANT_SECOND;
						end else if (phase_q == 2'd3) begin
							pad_d = PAD_DONE;
						end else begin
							err_d = ST_BADPAD;
						end
					end
					CLS_LETTER: begin
						if (ovf) begin
							err_d = ST_OVERFLOW;
						end else begin
							case (phase_q)
								2'd0: begin
									partial_d = pop_entry.val;
								end
								2'd1: begin
									res_byte  = {partial_q, pop_entry.val[5:4]};
									partial_d = {2'b00, pop_entry.val[3:0]};
								end
								2'd2: begin
									res_byte  = {partial_q[3:0], pop_entry.val[5:2]};
									partial_d = {4'b0000, pop_entry.val[1:0]};
								end
								default: begin
									res_byte  = {partial_q[1:0], pop_entry.val};
									partial_d = 6'd0;
								end
							endcase
							phase_d = phase_q + 2'd1;
							if (phase_q != 2'd0) begin
								res_valid = 1'b1;
								count_d   = count_q + 1'b1;
							end
						end
					end
					default: begin
						err_d = ST_BADCHAR;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 2'd0;
			partial_q   <= 6'd0;
			count_q     <= '0;
			pad_q       <= PAD_DATA;
			err_q       <= ST_OK;
			capacity_q  <= 16'hffff;
			out_valid_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			partial_q <= partial_d;
			count_q   <= count_d;
			pad_q     <= pad_d;
			err_q     <= err_d;
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			item_kind   <= res_kind;
			data_byte   <= res_byte;
			status_code <= res_status;
			byte_count  <= res_count;
			last_item   <= res_kind;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/base64_strict_decoder.sv
// Strict base64 decoder, top level: front end, item queue, back end.
// Depends on b64sd_pkg, b64sd_front, b64sd_queue, b64sd_back and the macro header.
//
//  channel  direction  handshake            payload
//  input    in         in_valid/in_stall    char_code, end_of_text
//  output   out        out_valid/out_stall  item_kind, data_byte, status_code,
//                                           byte_count, last_item
//  config   in         cfg_wr_en            cfg_wr_data (out_capacity)
//
// One character per cycle sustained while out_stall is low; a result passes through the queue
// entry written at the accepting edge, then into the output register when the back end pops and decodes it.
// Whitespace is consumed in the front end and takes no queue slot.
// Reset clears control state and out_valid at once, not queue storage or output payload; no clearing pass.
// out_stall holds the output register; the two-entry queue then fills and raises in_stall.
`include "base64_strict_decoder_macros.svh"

module base64_strict_decoder import b64sd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        item_kind,
	output logic [7:0]  data_byte,
	output logic [2:0]  status_code,
	output logic [15:0] byte_count,
	output logic        last_item
);

	q_status_t q_stat;
	logic      push;
	logic      pop;
	q_entry_t  push_entry;
	q_entry_t  pop_entry;

	b64sd_front u_front (
		.char_code  (char_code),
		.end_of_text(end_of_text),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	b64sd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.pop_entry (pop_entry),
		.q_stat    (q_stat)
	);

	b64sd_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.q_stat     (q_stat),
		.pop_entry  (pop_entry),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.item_kind  (item_kind),
		.data_byte  (data_byte),
		.status_code(status_code),
		.byte_count (byte_count),
		.last_item  (last_item)
	);

	`B64SD_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && q_stat.full)
	`B64SD_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && q_stat.empty)
	`B64SD_ASSERT_IMPLY(a_err_no_count, clk, arst_n, out_valid && status_code != ST_OK, item_kind == KIND_STATUS && byte_count == 16'd0)
	`B64SD_ASSERT_NEXT(a_full_stalls, clk, arst_n, in_valid && !in_stall && push && !pop && !q_stat.empty, in_stall)

endmodule
